FILE: hw/rtl/clcrf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clcrf_pkg
// shared types and constants of the camera line crop ring fifo
// ----------------------------------------------------------------------------
package clcrf_pkg;

  localparam int LINE_DEPTH = 1024;
  localparam int FIFO_DEPTH = 4096;
  localparam int LINE_AW    = $clog2(LINE_DEPTH);
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam int LW_W    = 12;
  localparam int LC_W    = 11;
  localparam int ROW_W   = 11;
  localparam int CMP_W   = (FIFO_AW > LW_W) ? FIFO_AW : LW_W;
  localparam int PADDR_W = 4;

  localparam logic [LW_W-1:0] LINE_WIDTH_RST = LW_W'(320);
  localparam logic [LC_W-1:0] LINE_COUNT_RST = LC_W'(240);

  typedef enum logic [2:0] {
    KIND_START    = 3'd0,
    KIND_FRAME    = 3'd1,
    KIND_PIXEL    = 3'd2,
    KIND_LINE_END = 3'd3,
    KIND_POP      = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    REG_LINE_WIDTH = 2'd0,
    REG_LINE_COUNT = 2'd1,
    REG_MONO_MODE  = 2'd2
  } reg_t;

  typedef enum logic {
    ST_RUN  = 1'b0,
    ST_COPY = 1'b1
  } state_t;

endpackage
`default_nettype wire

FILE: hw/rtl/clcrf_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clcrf_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module clcrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/camera_line_crop_ring_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// camera_line_crop_ring_fifo
// camera capture: pixel words fill a line store, wanted rows are cropped and
// copied into a byte ring at line end, pop beats read single bytes back
// ----------------------------------------------------------------------------
// flow: an accepted input beat sets the pend flag, from which its result beat
// is registered; the next input beat is taken in that same cycle, so one
// beat per cycle while the status side takes results. a copying line end
// registers its result after one line store read per byte; input waits.
// reset: control registers and pointers clear at once; line store and ring
// contents are not cleared and no clearing pass runs.
module camera_line_crop_ring_fifo (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  input  wire logic [15:0]                  s_tdata,   // pixel_word
  input  wire logic [2:0]                   s_tuser,   // kind
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  output logic      [7:0]                   m_tdata,   // data_byte
  output logic      [3:0]                   m_tuser,   // byte_valid, line_taken,
                                                       // capture_done, line_ready
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [clcrf_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                  pwdata,
  output logic      [31:0]                  prdata,
  output logic                              pready
);

  localparam int LINE_AW = clcrf_pkg::LINE_AW;
  localparam int FIFO_AW = clcrf_pkg::FIFO_AW;
  localparam int LW_W    = clcrf_pkg::LW_W;
  localparam int LC_W    = clcrf_pkg::LC_W;
  localparam int ROW_W   = clcrf_pkg::ROW_W;
  localparam int CMP_W   = clcrf_pkg::CMP_W;

  // configuration
  logic [LW_W-1:0] line_width;
  logic [LC_W-1:0] line_count;
  logic            mono_mode;

  // control state
  clcrf_pkg::state_t st, st_next;
  logic [FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [LINE_AW-1:0] col;
  logic [ROW_W-1:0]   scan_line, next_row;
  logic               active;
  logic               pend, pop_v, taken_q;
  logic [LW_W-1:0]    rd_i;
  logic               push_v, push_odd;

  // memories
  logic [15:0]        line_rdata;
  logic [7:0]         ring_rdata;
  logic               line_we, line_re, ring_we, ring_re;
  logic [LINE_AW-1:0] line_raddr;
  logic [7:0]         ring_wdata;

  // datapath helpers
  logic [FIFO_AW-1:0] count, free;
  logic               out_free, accept, take, issue, copy_end, line_ready_now;
  logic [LW_W-1:0]    src_idx;
  logic [15:0]        swapped;
  logic [ROW_W-1:0]   next_row_inc;
  logic               cfg_wr;

  assign pready   = 1'b1;
  assign cfg_wr   = psel & penable & pwrite;
  assign out_free = !m_tvalid || m_tready;
  assign count    = wr_ptr - rd_ptr;
  assign free     = FIFO_AW'(clcrf_pkg::FIFO_DEPTH - 1) - count;
  assign accept   = s_tvalid && s_tready;
  assign take     = active && (scan_line == next_row)
                 && (CMP_W'(next_row) < CMP_W'(line_count))
                 && (CMP_W'(free) >= CMP_W'(line_width));
  assign issue    = (st == clcrf_pkg::ST_COPY) && (rd_i < line_width);
  assign copy_end = (st == clcrf_pkg::ST_COPY) && !issue && !push_v;
  assign next_row_inc   = next_row + 1'b1;
  assign line_ready_now = CMP_W'(count) >= CMP_W'(line_width);

  // line store read index, clamped to the last entry
  always_comb begin
    src_idx = mono_mode ? (rd_i >> 1) : rd_i;
    if ({1'b0, src_idx} >= (LW_W+1)'(clcrf_pkg::LINE_DEPTH)) begin
      line_raddr = LINE_AW'(clcrf_pkg::LINE_DEPTH - 1);
    end else begin
      line_raddr = src_idx[LINE_AW-1:0];
    end
  end

  always_comb begin
    swapped = {line_rdata[7:0], line_rdata[15:8]};
    if (mono_mode) begin
      ring_wdata = push_odd ? line_rdata[15:8] : line_rdata[7:0];
    end else begin
      ring_wdata = {swapped[10:5], 2'b00};
    end
  end

  assign line_we = accept && (s_tuser == clcrf_pkg::KIND_PIXEL);
  assign line_re = issue;
  assign ring_we = push_v;
  assign ring_re = accept && (s_tuser == clcrf_pkg::KIND_POP) && (count != '0);

  clcrf_ram #(.WIDTH(16), .DEPTH(clcrf_pkg::LINE_DEPTH)) u_line_ram (
    .clk   (clk),
    .we    (line_we),
    .waddr (col),
    .wdata (s_tdata),
    .re    (line_re),
    .raddr (line_raddr),
    .rdata (line_rdata)
  );

  clcrf_ram #(.WIDTH(8), .DEPTH(clcrf_pkg::FIFO_DEPTH)) u_ring_ram (
    .clk   (clk),
    .we    (ring_we),
    .waddr (wr_ptr),
    .wdata (ring_wdata),
    .re    (ring_re),
    .raddr (rd_ptr),
    .rdata (ring_rdata)
  );

  // state machine
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= clcrf_pkg::ST_RUN;
    end else begin
      st <= st_next;
    end
  end

  always_comb begin
    st_next  = st;
    s_tready = 1'b0;
    case (st)
      clcrf_pkg::ST_RUN: begin
        s_tready = !pend || out_free;
        if (accept && (s_tuser == clcrf_pkg::KIND_LINE_END) && take) begin
          st_next = clcrf_pkg::ST_COPY;
        end
      end
      clcrf_pkg::ST_COPY: begin
        if (copy_end) begin
          st_next = clcrf_pkg::ST_RUN;
        end
      end
      default: st_next = clcrf_pkg::ST_RUN;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= clcrf_pkg::LINE_WIDTH_RST;
      line_count <= clcrf_pkg::LINE_COUNT_RST;
      mono_mode  <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        clcrf_pkg::REG_LINE_WIDTH: line_width <= pwdata[LW_W-1:0];
        clcrf_pkg::REG_LINE_COUNT: line_count <= pwdata[LC_W-1:0];
        clcrf_pkg::REG_MONO_MODE:  mono_mode  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      clcrf_pkg::REG_LINE_WIDTH: prdata = 32'(line_width);
      clcrf_pkg::REG_LINE_COUNT: prdata = 32'(line_count);
      clcrf_pkg::REG_MONO_MODE:  prdata = 32'(mono_mode);
      default:                   prdata = '0;
    endcase
  end

  // capture control and copy engine
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      col       <= '0;
      scan_line <= '0;
      next_row  <= '0;
      active    <= 1'b0;
      pend      <= 1'b0;
      pop_v     <= 1'b0;
      taken_q   <= 1'b0;
      rd_i      <= '0;
      push_v    <= 1'b0;
      push_odd  <= 1'b0;
    end else begin
      if (pend && out_free) begin
        pend <= 1'b0;
      end

      if (accept) begin
        pend    <= 1'b1;
        pop_v   <= 1'b0;
        taken_q <= 1'b0;
        case (s_tuser)
          clcrf_pkg::KIND_START: begin
            active    <= 1'b1;
            wr_ptr    <= '0;
            rd_ptr    <= '0;
            scan_line <= '0;
            next_row  <= '0;
            col       <= '0;
          end
          clcrf_pkg::KIND_FRAME: begin
            scan_line <= '0;
            col       <= '0;
          end
          clcrf_pkg::KIND_PIXEL: begin
            if (col != LINE_AW'(clcrf_pkg::LINE_DEPTH - 1)) begin
              col <= col + 1'b1;
            end
          end
          clcrf_pkg::KIND_LINE_END: begin
            col       <= '0;
            scan_line <= scan_line + 1'b1;
            if (take) begin
              pend <= 1'b0;
              rd_i <= '0;
            end
          end
          clcrf_pkg::KIND_POP: begin
            if (count != '0) begin
              pop_v  <= 1'b1;
              rd_ptr <= rd_ptr + 1'b1;
            end
          end
          default: ;
        endcase
      end

      push_v <= issue;
      if (issue) begin
        push_odd <= rd_i[0];
        rd_i     <= rd_i + 1'b1;
      end
      if (push_v) begin
        wr_ptr <= wr_ptr + 1'b1;
      end

      if (copy_end) begin
        next_row <= next_row_inc;
        if (CMP_W'(next_row_inc) >= CMP_W'(line_count)) begin
          active <= 1'b0;
        end
        taken_q <= 1'b1;
        pend    <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pend && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend && out_free) begin
      m_tdata <= pop_v ? ring_rdata : 8'h00;
      m_tuser <= {line_ready_now,
                  !active || (CMP_W'(next_row) >= CMP_W'(line_count)),
                  taken_q,
                  pop_v};
    end
  end

  // checks
  a_no_accept_in_copy: assert property (@(posedge clk) disable iff (rst)
    (st == clcrf_pkg::ST_COPY) |-> !s_tready)
    else $error("input beat accepted during line copy");

  a_no_pend_in_copy: assert property (@(posedge clk) disable iff (rst)
    (st == clcrf_pkg::ST_COPY) |-> !pend)
    else $error("result pending while line copy runs");

  a_push_only_in_copy: assert property (@(posedge clk) disable iff (rst)
    push_v |-> (st == clcrf_pkg::ST_COPY))
    else $error("ring write outside line copy");

  a_ring_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push_v |-> (count != FIFO_AW'(clcrf_pkg::FIFO_DEPTH - 1)))
    else $error("ring overflow during line copy");

  a_copy_ends_taken: assert property (@(posedge clk) disable iff (rst)
    copy_end |=> (pend && taken_q && (st == clcrf_pkg::ST_RUN)))
    else $error("line copy finished without a taken result");

endmodule
`default_nettype wire

FILE: tb/camera_line_crop_ring_fifo_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// camera_line_crop_ring_fifo_tb
// drives sensor beats (capture start, frame start, pixel words, line ends,
// byte pops) into the capture block and predicts every status beat from a
// behavioral copy of the line store, the byte ring and the row tracking.
// window registers are changed over the apb port between runs while the
// block is idle, and read back. both stream sides idle at random, and the
// status side holds off once for a long stretch to back the block up.
// ----------------------------------------------------------------------------
module camera_line_crop_ring_fifo_tb;
  import clcrf_pkg::*;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] word;
  } sensor_beat_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       line_taken;
    logic       capture_done;
    logic       line_ready;
  } status_beat_t;

  logic                clk;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [15:0]         s_tdata  = '0;   // pixel_word
  logic [2:0]          s_tuser  = '0;   // kind
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [7:0]          m_tdata;         // data_byte
  logic [3:0]          m_tuser;         // byte_valid, line_taken, capture_done, line_ready
  logic                psel     = 1'b0;
  logic                penable  = 1'b0;
  logic                pwrite   = 1'b0;
  logic [PADDR_W-1:0]  paddr    = '0;
  logic [31:0]         pwdata   = '0;
  logic [31:0]         prdata;
  logic                pready;

  camera_line_crop_ring_fifo uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // window settings as the block should hold them
  logic [LW_W-1:0]    cfg_line_width = LINE_WIDTH_RST;
  logic [LC_W-1:0]    cfg_line_count = LINE_COUNT_RST;
  logic               cfg_mono       = 1'b0;

  // behavioral copy of the capture state
  logic [15:0]        line_words [LINE_DEPTH];
  logic [7:0]         ring_bytes [FIFO_DEPTH];
  logic [FIFO_AW-1:0] ring_wr    = '0;
  logic [FIFO_AW-1:0] ring_rd    = '0;
  int unsigned        column     = 0;
  logic [ROW_W-1:0]   scan_row   = '0;
  logic [ROW_W-1:0]   wanted_row = '0;
  logic               capturing  = 1'b0;

  sensor_beat_t       sensor_beats[$];
  status_beat_t       expected_status[$];
  int unsigned        beats_queued  = 0;
  int unsigned        status_seen   = 0;
  int unsigned        mismatches    = 0;
  int unsigned        send_idle     = 0;
  int unsigned        send_steady   = 0;
  int unsigned        recv_idle     = 0;
  int unsigned        recv_steady   = 0;
  bit                 long_hold_done = 1'b0;

  function automatic int unsigned ring_fill();
    return int'(FIFO_AW'(ring_wr - ring_rd));
  endfunction

  function automatic status_beat_t predict_capture_status(logic [2:0] kind,
                                                          logic [15:0] word);
    status_beat_t res;
    logic [15:0]  px;
    logic [15:0]  swapped;
    int unsigned  idx;
    res = '0;
    case (kind)
      KIND_START: begin
        capturing  = 1'b1;
        ring_wr    = '0;
        ring_rd    = '0;
        scan_row   = '0;
        wanted_row = '0;
        column     = 0;
      end
      KIND_FRAME: begin
        scan_row = '0;
        column   = 0;
      end
      KIND_PIXEL: begin
        line_words[column] = word;
        if (column < LINE_DEPTH - 1) column++;
      end
      KIND_LINE_END: begin
        if (capturing && scan_row == wanted_row && wanted_row < cfg_line_count &&
            (FIFO_DEPTH - 1) - ring_fill() >= cfg_line_width) begin
          for (int i = 0; i < cfg_line_width; i++) begin
            idx = cfg_mono ? (i >> 1) : i;
            if (idx > LINE_DEPTH - 1) idx = LINE_DEPTH - 1;
            px = line_words[idx];
            if (cfg_mono) begin
              ring_bytes[ring_wr] = (i % 2) ? px[15:8] : px[7:0];
            end else begin
              swapped = {px[7:0], px[15:8]};
              ring_bytes[ring_wr] = {swapped[10:5], 2'b00};
            end
            ring_wr++;
          end
          wanted_row++;
          if (wanted_row >= cfg_line_count) capturing = 1'b0;
          res.line_taken = 1'b1;
        end
        column = 0;
        scan_row++;
      end
      KIND_POP: begin
        if (ring_fill() > 0) begin
          res.data_byte  = ring_bytes[ring_rd];
          res.byte_valid = 1'b1;
          ring_rd++;
        end
      end
      default: begin
      end
    endcase
    res.capture_done = !capturing || wanted_row >= cfg_line_count;
    res.line_ready   = ring_fill() >= cfg_line_width;
    return res;
  endfunction

  function automatic int unsigned next_idle(ref int unsigned steady);
    int unsigned r;
    if (steady > 0) begin
      steady--;
      return 0;
    end
    if ($urandom_range(0, 199) == 0) steady = $urandom_range(100, 300);
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      mismatches++;
    end
  endfunction

  // sensor side driver
  always @(posedge clk) begin : feed_sensor
    sensor_beat_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (send_idle > 0) begin
        send_idle--;
        s_tvalid <= 1'b0;
      end else if (sensor_beats.size() == 0) begin
        s_tvalid <= 1'b0;
      end else begin
        nxt = sensor_beats.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= nxt.word;
        s_tuser  <= nxt.kind;
        send_idle = next_idle(send_steady);
      end
    end
  end

  // status side ready, with one long hold-off while beats are still queued
  always @(posedge clk) begin : drain_status
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (!long_hold_done && status_seen >= 1500 && sensor_beats.size() > 100) begin
        long_hold_done = 1'b1;
        recv_idle      = 400;
      end
      if (recv_idle > 0) begin
        recv_idle--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        recv_idle = next_idle(recv_steady);
      end
    end
  end

  // predict on accepted sensor beats, check accepted status beats
  always @(posedge clk) begin : watch_beats
    status_beat_t got;
    status_beat_t want;
    if (!rst) begin
      if (s_tvalid && s_tready)
        expected_status.push_back(predict_capture_status(s_tuser, s_tdata));
      if (m_tvalid && m_tready) begin
        status_seen++;
        got = {m_tdata, m_tuser[0], m_tuser[1], m_tuser[2], m_tuser[3]};
        if (expected_status.size() == 0) begin
          $error("status beat with nothing expected: %0h", got);
          mismatches++;
        end else begin
          want = expected_status.pop_front();
          check_field("data_byte", want.data_byte, got.data_byte);
          check_field("byte_valid", want.byte_valid, got.byte_valid);
          check_field("line_taken", want.line_taken, got.line_taken);
          check_field("capture_done", want.capture_done, got.capture_done);
          check_field("line_ready", want.line_ready, got.line_ready);
        end
      end
    end
  end

  task automatic add_beat(logic [2:0] kind, logic [15:0] word);
    sensor_beats.push_back('{kind, word});
    beats_queued++;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (!(sensor_beats.size() == 0 && !s_tvalid && expected_status.size() == 0));
    repeat (8) @(posedge clk);
  endtask

  task automatic write_capture_reg(reg_t idx, logic [31:0] value);
    logic [31:0] want;
    case (idx)
      REG_LINE_WIDTH: want = value & ((32'd1 << LW_W) - 1);
      REG_LINE_COUNT: want = value & ((32'd1 << LC_W) - 1);
      default:        want = value & 32'd1;
    endcase
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(4 * idx);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_LINE_WIDTH: cfg_line_width = want[LW_W-1:0];
      REG_LINE_COUNT: cfg_line_count = want[LC_W-1:0];
      default:        cfg_mono       = want[0];
    endcase
    @(posedge clk);
    psel    <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== want) begin
      $error("prdata: expected %0h, got %0h", want, prdata);
      mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_capture_window(int unsigned width, int unsigned rows, bit mono);
    write_capture_reg(REG_LINE_WIDTH, width);
    write_capture_reg(REG_LINE_COUNT, rows);
    write_capture_reg(REG_MONO_MODE, mono);
  endtask

  // mostly well formed frames with random content, some noise and broken lines
  task automatic queue_capture_run(int unsigned budget);
    int unsigned stop;
    int unsigned need;
    int unsigned words;
    int unsigned pops;
    int unsigned pick;
    stop = beats_queued + budget;
    add_beat(KIND_START, 16'($urandom));
    while (beats_queued < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        add_beat(KIND_START, 16'($urandom));
      end else if (pick < 12) begin
        add_beat(3'($urandom_range(0, 7)), 16'($urandom));
      end else begin
        add_beat(KIND_FRAME, 16'($urandom));
        repeat ($urandom_range(1, 8)) begin
          need = cfg_mono ? (cfg_line_width + 1) / 2 : cfg_line_width;
          if (need > 40) need = 40;
          words = ($urandom_range(0, 4) == 0) ? $urandom_range(0, need + 2) : need;
          repeat (words) begin
            add_beat(KIND_PIXEL, 16'($urandom));
            if ($urandom_range(0, 7) == 0) add_beat(KIND_POP, 16'($urandom));
          end
          if ($urandom_range(0, 19) != 0) add_beat(KIND_LINE_END, 16'($urandom));
          need = (cfg_line_width > 48) ? 48 : cfg_line_width;
          pops = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, need + 2);
          repeat (pops) add_beat(KIND_POP, 16'($urandom));
        end
      end
    end
  endtask

  // fill the ring, free a little room, then run the scan row all the way round
  task automatic queue_scan_wrap();
    add_beat(KIND_START, 16'($urandom));
    for (int n = 0; n < 2320; n++) begin
      if (n == 1000) repeat (40) add_beat(KIND_POP, 16'($urandom));
      add_beat(KIND_LINE_END, 16'($urandom));
    end
  endtask

  initial begin : stimulus
    int unsigned random_base;
    int unsigned fixed_width[7] = '{8, 7, 1, 2048, 0, 16, 5};
    int unsigned fixed_rows[7]  = '{4, 3, 1024, 3, 2, 0, 2};
    bit          fixed_mono[7]  = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1};
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // every line store entry written, column runs past the end and holds at the last entry
    repeat (LINE_DEPTH + 6) add_beat(KIND_PIXEL, 16'($urandom));
    add_beat(KIND_LINE_END, 16'($urandom));

    add_beat(KIND_POP, 16'h0000);
    add_beat(3'd5, 16'hffff);
    add_beat(3'd6, 16'hffff);
    add_beat(3'd7, 16'hffff);
    add_beat(KIND_LINE_END, 16'h0000);
    add_beat(KIND_FRAME, 16'h0000);
    add_beat(KIND_START, 16'h0000);
    add_beat(KIND_PIXEL, 16'h0000);
    add_beat(KIND_PIXEL, 16'hffff);
    add_beat(KIND_PIXEL, 16'ha5a5);
    add_beat(KIND_PIXEL, 16'h5a5a);
    add_beat(KIND_LINE_END, 16'h0000);
    repeat (3) add_beat(KIND_POP, 16'h0000);
    add_beat(KIND_FRAME, 16'h0000);
    add_beat(KIND_PIXEL, 16'h0001);
    add_beat(KIND_LINE_END, 16'h0000);
    add_beat(KIND_LINE_END, 16'h0000);
    add_beat(KIND_POP, 16'h0000);
    wait_idle();

    random_base = beats_queued;
    for (int p = 0; p < 7; p++) begin
      set_capture_window(fixed_width[p], fixed_rows[p], fixed_mono[p]);
      queue_capture_run(200);
      wait_idle();
    end

    set_capture_window(16, 1024, 1'b0);
    queue_scan_wrap();
    wait_idle();
    random_base += beats_queued - random_base - 2361;

    while (beats_queued - random_base < 2000) begin
      set_capture_window($urandom_range(1, 40), $urandom_range(1, 10), $urandom_range(0, 1));
      queue_capture_run(250);
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("camera_line_crop_ring_fifo_tb OK");
    end else begin
      $display("camera_line_crop_ring_fifo_tb NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("camera_line_crop_ring_fifo_tb NOT OK");
    $finish;
  end

endmodule
